/* sv/b64d_pkg.sv */
package b64d_pkg;

  localparam int unsigned QUEUE_DEPTH = 4;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_LENGTH  = 2'd1;
  localparam logic [1:0] ST_INVALID = 2'd2;

  localparam logic [7:0] PAD_CHAR = 8'd61;

  // result slots of one job, in emission order
  localparam int unsigned SLOT_BYTE0 = 0;
  localparam int unsigned SLOT_BYTE1 = 1;
  localparam int unsigned SLOT_BYTE2 = 2;
  localparam int unsigned SLOT_ERR   = 3;
  localparam int unsigned N_SLOTS    = 4;

  typedef struct packed {
    logic [7:0] code_char;
    logic       end_of_text;
  } in_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic [1:0] status;
    logic       last_of_text;
  } out_t;

  // one unit of work handed from the front to the back
  typedef struct packed {
    logic [23:0]        triple;
    logic [N_SLOTS-1:0] slots;
    logic [1:0]         err_status;
    logic               last;
  } job_t;

  typedef struct packed {
    logic       ok;
    logic [5:0] val;
  } sextet_t;

  function automatic sextet_t char_to_sextet(input logic [7:0] c);
    sextet_t r;
    r.ok  = 1'b1;
    r.val = 6'd0;
    if (c inside {[8'd65:8'd90]}) begin
      r.val = 6'(c - 8'd65);
    end else if (c inside {[8'd97:8'd122]}) begin
      r.val = 6'(c - 8'd71);
    end else if (c inside {[8'd48:8'd57]}) begin
      r.val = 6'(c + 8'd4);
    end else if (c == 8'd43) begin
      r.val = 6'd62;
    end else if (c == 8'd47) begin
      r.val = 6'd63;
    end else if (c == PAD_CHAR) begin
      r.val = 6'd0;
    end else begin
      r.ok = 1'b0;
    end
    return r;
  endfunction

endpackage

/* sv/b64d_front.sv */
module b64d_front (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  input  b64d_pkg::in_t in_data,
  output logic          push,
  output b64d_pkg::job_t push_job,
  input  logic          q_full
);

  logic [17:0] acc_r, acc_nxt;
  logic [1:0]  pos_r, pos_nxt;
  logic        tpad_r, tpad_nxt;
  logic        disc_r, disc_nxt;

  b64d_pkg::sextet_t sx;
  logic accept;
  logic is_pad;

  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;
  assign sx       = b64d_pkg::char_to_sextet(in_data.code_char);
  assign is_pad   = (in_data.code_char == b64d_pkg::PAD_CHAR);

  always_comb begin
    acc_nxt  = acc_r;
    pos_nxt  = pos_r;
    tpad_nxt = tpad_r;
    disc_nxt = disc_r;
    push     = 1'b0;
    push_job = '0;
    if (accept) begin
      if (disc_r) begin
        if (in_data.end_of_text) begin
          disc_nxt = 1'b0;
          acc_nxt  = '0;
          pos_nxt  = '0;
          tpad_nxt = 1'b0;
        end
      end else if (!sx.ok) begin
        push                = 1'b1;
        push_job.slots[b64d_pkg::SLOT_ERR] = 1'b1;
        push_job.err_status = b64d_pkg::ST_INVALID;
        push_job.last       = 1'b1;
        acc_nxt  = '0;
        pos_nxt  = '0;
        tpad_nxt = 1'b0;
        disc_nxt = !in_data.end_of_text;
      end else if (pos_r == 2'd3) begin
        push            = 1'b1;
        push_job.triple = {acc_r, sx.val};
        push_job.slots[b64d_pkg::SLOT_BYTE0] = 1'b1;
        push_job.slots[b64d_pkg::SLOT_BYTE1] = !tpad_r;
        push_job.slots[b64d_pkg::SLOT_BYTE2] = !is_pad;
        push_job.err_status = b64d_pkg::ST_OK;
        push_job.last       = in_data.end_of_text;
        acc_nxt  = '0;
        pos_nxt  = '0;
        tpad_nxt = 1'b0;
      end else begin
        acc_nxt = {acc_r[11:0], sx.val};
        pos_nxt = pos_r + 2'd1;
        if (pos_r == 2'd2) begin
          tpad_nxt = is_pad;
        end
        if (in_data.end_of_text) begin
          push                = 1'b1;
          push_job.slots[b64d_pkg::SLOT_ERR] = 1'b1;
          push_job.err_status = b64d_pkg::ST_LENGTH;
          push_job.last       = 1'b1;
          acc_nxt  = '0;
          pos_nxt  = '0;
          tpad_nxt = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r  <= '0;
      pos_r  <= '0;
      tpad_r <= 1'b0;
      disc_r <= 1'b0;
    end else begin
      acc_r  <= acc_nxt;
      pos_r  <= pos_nxt;
      tpad_r <= tpad_nxt;
      disc_r <= disc_nxt;
    end
  end

endmodule

/* sv/b64d_queue.sv */
module b64d_queue #(
  parameter int unsigned DEPTH = b64d_pkg::QUEUE_DEPTH
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  b64d_pkg::job_t push_job,
  output logic           full,
  input  logic           pop,
  output logic           empty,
  output b64d_pkg::job_t head
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST_IDX = PW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  b64d_pkg::job_t slot_r [DEPTH];
  logic [PW-1:0] wr_r, rd_r;
  logic [CW-1:0] cnt_r;
  logic do_push, do_pop;

  assign full    = (cnt_r == FULL_CNT);
  assign empty   = (cnt_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign head    = slot_r[rd_r];

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_r] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (do_push) begin
        wr_r <= (wr_r == LAST_IDX) ? '0 : wr_r + PW'(1);
      end
      if (do_pop) begin
        rd_r <= (rd_r == LAST_IDX) ? '0 : rd_r + PW'(1);
      end
      if (do_push && !do_pop) begin
        cnt_r <= cnt_r + CW'(1);
      end else if (do_pop && !do_push) begin
        cnt_r <= cnt_r - CW'(1);
      end
    end
  end

endmodule

/* sv/b64d_back.sv */
module b64d_back (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           q_empty,
  input  b64d_pkg::job_t q_head,
  output logic           pop,
  output logic           out_valid,
  input  logic           out_stall,
  output b64d_pkg::out_t out_data
);

  localparam int unsigned NS = b64d_pkg::N_SLOTS;

  b64d_pkg::job_t job_r, job_nxt;
  logic [NS-1:0]  pend_r, pend_nxt;
  logic           ovld_r, ovld_nxt;
  b64d_pkg::out_t odat_r, odat_nxt;

  logic          slot_free, emit;
  logic [NS-1:0] sel, pend_after;

  assign slot_free = !ovld_r || !out_stall;
  assign emit      = slot_free && (pend_r != '0);
  // lowest pending slot goes first
  assign sel        = pend_r & (~pend_r + NS'(1));
  assign pend_after = emit ? (pend_r & ~sel) : pend_r;
  assign pop        = (pend_after == '0) && !q_empty;

  always_comb begin
    job_nxt  = pop ? q_head : job_r;
    pend_nxt = pop ? q_head.slots : pend_after;
    ovld_nxt = ovld_r;
    odat_nxt = odat_r;
    if (emit) begin
      ovld_nxt              = 1'b1;
      odat_nxt.last_of_text = job_r.last && (pend_after == '0);
      odat_nxt.status       = b64d_pkg::ST_OK;
      odat_nxt.data_byte    = 8'd0;
      if (sel[b64d_pkg::SLOT_BYTE0]) begin
        odat_nxt.data_byte = job_r.triple[23:16];
      end else if (sel[b64d_pkg::SLOT_BYTE1]) begin
        odat_nxt.data_byte = job_r.triple[15:8];
      end else if (sel[b64d_pkg::SLOT_BYTE2]) begin
        odat_nxt.data_byte = job_r.triple[7:0];
      end else begin
        odat_nxt.status = job_r.err_status;
      end
    end else if (slot_free) begin
      ovld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    job_r  <= job_nxt;
    odat_r <= odat_nxt;
    if (!rst_n) begin
      pend_r <= '0;
      ovld_r <= 1'b0;
    end else begin
      pend_r <= pend_nxt;
      ovld_r <= ovld_nxt;
    end
  end

  assign out_valid = ovld_r;
  assign out_data  = odat_r;

endmodule

/* sv/base64_stream_decoder.sv */
// path: a result beat is registered in the job queue, the back end's job register and the output register
// throughput: one character beat per cycle unless in_stall; one result beat per cycle unless out_stall
// a full group of four characters yields at most three bytes, so the job queue drains in step
// reset: synchronous active-low rst_n clears the group, discard flag, queue and output valid
module base64_stream_decoder #(
  parameter int unsigned QUEUE_DEPTH = b64d_pkg::QUEUE_DEPTH
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_stall,
  input  b64d_pkg::in_t  in_data,
  output logic           out_valid,
  input  logic           out_stall,
  output b64d_pkg::out_t out_data
);

  // front: classifies each character, keeps the partial group, builds jobs
  logic           push;
  b64d_pkg::job_t push_job;
  logic           q_full, q_empty, pop;
  b64d_pkg::job_t q_head;

  b64d_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .push     (push),
    .push_job (push_job),
    .q_full   (q_full)
  );

  // short job queue so front and back stall independently
  b64d_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_job (push_job),
    .full     (q_full),
    .pop      (pop),
    .empty    (q_empty),
    .head     (q_head)
  );

  // back: walks the pending result slots of a job, one beat per cycle unless out_stall holds the output
  b64d_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_empty   (q_empty),
    .q_head    (q_head),
    .pop       (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule
